>>> rtl/log_record_reassembler_unit_assert.svh
// Assertion macros for the log record reassembler result buffer.
`ifndef LOG_RECORD_REASSEMBLER_UNIT_ASSERT_SVH
`define LOG_RECORD_REASSEMBLER_UNIT_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define LRR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define LRR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/lrr_pkg.sv
// Types, constants and the CRC32C byte step of the log record reassembler.
package lrr_pkg;

	localparam int OFFW = 48;
	localparam int BLOCK_SIZE = 32768;
	localparam int HEADER_SIZE = 7;
	localparam int BPW = $clog2(BLOCK_SIZE);
	localparam int MAX_RES = 3;
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;
	localparam logic [31:0] CRC_MASK_DELTA = 32'ha282ead8;

	localparam logic REG_INITIAL_OFFSET = 1'b0;
	localparam logic REG_CHECKSUM_ENABLE = 1'b1;

	localparam logic [7:0] TYPE_FULL = 8'd1;
	localparam logic [7:0] TYPE_FIRST = 8'd2;
	localparam logic [7:0] TYPE_MIDDLE = 8'd3;
	localparam logic [7:0] TYPE_LAST = 8'd4;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_SKIP = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_ABORT = 2'd2,
		KIND_END = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] payload_byte;
		logic [OFFW-1:0] record_offset;
		logic last;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

>>> rtl/log_record_reassembler_unit.sv
// Top level of the log record reassembler.
// The block parses a block-structured log file one byte per item and rebuilds
// its records, giving tentative payload bytes, commits with the record's first
// header offset, aborts and a final end-of-log result. An item with at most
// one result is accepted every cycle while out_ready is high; one with more
// (up to three) holds the input until only its last result waits, as the
// three-entry result buffer hands out one result per cycle while out_ready
// is high. The per-byte CRC32C step and parser state update are combinational
// between the input handshake and the result buffer. No clearing pass runs after
// reset. After the byte marked last, items are accepted with no results until reset.
module log_record_reassembler_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_index,
	input  logic [lrr_pkg::OFFW-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic is_last_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [lrr_pkg::OFFW-1:0] record_offset,
	output logic last
);
	import lrr_pkg::*;

	logic accept;
	logic [1:0] res_cnt;
	result_t res [MAX_RES];
	result_t out_res;

	assign accept = in_valid && in_ready;

	lrr_core u_core (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.accept(accept), .data_byte(data_byte), .is_last_byte(is_last_byte),
		.res_cnt(res_cnt), .res(res)
	);

	lrr_outq u_outq (
		.clk(clk), .arst_n(arst_n),
		.load(accept), .load_cnt(res_cnt), .load_res(res),
		.out_ready(out_ready), .in_ready(in_ready),
		.out_valid(out_valid), .out_res(out_res)
	);

	assign kind = out_res.kind;
	assign payload_byte = out_res.payload_byte;
	assign record_offset = out_res.record_offset;
	assign last = out_res.last;

endmodule

>>> rtl/lrr_core.sv
// Parser state and the per-byte step that produces up to three results.
module lrr_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_index,
	input  logic [lrr_pkg::OFFW-1:0] cfg_wdata,
	input  logic accept,
	input  logic [7:0] data_byte,
	input  logic is_last_byte,
	output logic [1:0] res_cnt,
	output lrr_pkg::result_t res [lrr_pkg::MAX_RES]
);
	import lrr_pkg::*;

	logic [OFFW-1:0] init_q, fpos_q, poff_q, choff_q;
	logic [OFFW:0] start_q;
	logic chk_q;
	logic [BPW-1:0] bpos_q;
	phase_t phase_q;
	logic [55:0] hshift_q;
	logic [2:0] hcnt_q;
	logic [15:0] prem_q;
	logic [31:0] crc_q;
	logic [7:0] rtype_q;
	logic infrag_q, resync_q, tpend_q, emitc_q, ended_q;

	logic [OFFW-1:0] fpos_d, poff_d, choff_d;
	logic [BPW-1:0] bpos_d;
	phase_t phase_d;
	logic [55:0] hshift_d;
	logic [2:0] hcnt_d;
	logic [15:0] prem_d;
	logic [31:0] crc_d;
	logic [7:0] rtype_d;
	logic infrag_d, resync_d, tpend_d, emitc_d, ended_d;

	logic [OFFW-1:0] cfg_in_blk;
	logic [OFFW:0] cfg_start;

	// The parse start is the block holding the initial offset, or the next one
	// when the offset sits in a block's last five bytes. The extra bit keeps a
	// start past the top of the offset range from wrapping to zero.
	always_comb begin
		cfg_in_blk = cfg_wdata % OFFW'(BLOCK_SIZE);
		cfg_start = {1'b0, cfg_wdata - cfg_in_blk};
		if (cfg_in_blk > OFFW'(BLOCK_SIZE - 6)) begin
			cfg_start = cfg_start + (OFFW+1)'(BLOCK_SIZE);
		end
	end

	always_comb begin
		logic [1:0] n;
		logic do_finish, do_bad, bad_skip, drop, crc_ok, off_ok;
		logic [17:0] hs;
		logic [15:0] len;
		logic [7:0] typ;
		logic [31:0] c, masked;
		logic [BPW:0] bnext;

		fpos_d = fpos_q; bpos_d = bpos_q; phase_d = phase_q; hshift_d = hshift_q;
		hcnt_d = hcnt_q; prem_d = prem_q; crc_d = crc_q; rtype_d = rtype_q;
		infrag_d = infrag_q; resync_d = resync_q; tpend_d = tpend_q; emitc_d = emitc_q;
		poff_d = poff_q; choff_d = choff_q; ended_d = ended_q;
		n = 2'd0; do_finish = 1'b0; do_bad = 1'b0; bad_skip = 1'b0; drop = 1'b0;
		crc_ok = 1'b1; off_ok = 1'b1; c = '0; masked = '0;
		hs = '0; len = '0; typ = '0; bnext = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '{kind: KIND_DATA, payload_byte: 8'd0, record_offset: '0, last: 1'b0};
		end

		if (!ended_q) begin
			if ({1'b0, fpos_q} >= start_q) begin
				case (phase_q)
					PH_HEADER: begin
						if (hcnt_q == 3'd0) begin
							if (18'(BLOCK_SIZE) - {{(18-BPW){1'b0}}, bpos_q} < 18'(HEADER_SIZE)) begin
								phase_d = PH_SKIP;
							end else begin
								choff_d = fpos_q;
								hshift_d = '0;
							end
						end
						if (phase_d == PH_HEADER) begin
							hshift_d = {data_byte, hshift_d[55:8]};
							hcnt_d = hcnt_d + 3'd1;
							if (hcnt_d >= 3'(HEADER_SIZE)) begin
								hcnt_d = 3'd0;
								hs = {{(18-BPW){1'b0}}, bpos_q} - 18'(HEADER_SIZE - 1);
								len = hshift_d[47:32];
								typ = hshift_d[55:48];
								off_ok = choff_d >= init_q;
								if (18'(HEADER_SIZE) + {2'b0, len} > 18'(BLOCK_SIZE) - hs) begin
									do_bad = 1'b1; bad_skip = 1'b1;
								end else if (typ == 8'd0 && len == 16'd0) begin
									// Zero padding fills the rest of the block.
									do_bad = 1'b1; bad_skip = 1'b1;
								end else begin
									rtype_d = typ;
									if (typ != TYPE_MIDDLE && typ != TYPE_LAST) begin
										if (tpend_d) begin
											res[n].kind = KIND_ABORT;
											n = n + 2'd1;
											tpend_d = 1'b0;
										end
										infrag_d = 1'b0;
									end
									if (typ == TYPE_FULL || typ == TYPE_FIRST) begin
										emitc_d = off_ok;
									end else if (typ == TYPE_MIDDLE || typ == TYPE_LAST) begin
										emitc_d = infrag_d && off_ok;
									end else begin
										emitc_d = 1'b0;
									end
									crc_d = crc_byte(32'hffffffff, typ);
									prem_d = len;
									if (len == 16'd0) begin
										do_finish = 1'b1;
									end else begin
										phase_d = PH_PAYLOAD;
									end
								end
							end
						end
					end
					PH_PAYLOAD: begin
						if (emitc_q) begin
							res[n].kind = KIND_DATA;
							res[n].payload_byte = data_byte;
							n = n + 2'd1;
							tpend_d = 1'b1;
						end
						crc_d = crc_byte(crc_q, data_byte);
						if (prem_d != 16'd0) begin
							prem_d = prem_d - 16'd1;
						end
						if (prem_d == 16'd0) begin
							do_finish = 1'b1;
						end
					end
					default: ;
				endcase
			end

			if (do_finish) begin
				c = ~crc_d;
				masked = {c[14:0], c[31:15]} + CRC_MASK_DELTA;
				crc_ok = !chk_q || (masked == hshift_d[31:0]);
				off_ok = choff_d >= init_q;
				if (!crc_ok || !off_ok) begin
					do_bad = 1'b1;
					bad_skip = !crc_ok;
				end else begin
					phase_d = PH_HEADER;
					// While resyncing, trailing pieces of a record cut by the start
					// point are discarded.
					if (resync_d) begin
						if (rtype_d == TYPE_MIDDLE) begin
							drop = 1'b1;
						end else begin
							resync_d = 1'b0;
							if (rtype_d == TYPE_LAST) drop = 1'b1;
						end
					end
					if (!drop) begin
						case (rtype_d)
							TYPE_FULL: begin
								res[n].kind = KIND_COMMIT;
								res[n].record_offset = choff_d;
								n = n + 2'd1;
								tpend_d = 1'b0;
								infrag_d = 1'b0;
							end
							TYPE_FIRST: begin
								poff_d = choff_d;
								infrag_d = 1'b1;
							end
							TYPE_MIDDLE: ;
							TYPE_LAST: begin
								if (infrag_d) begin
									res[n].kind = KIND_COMMIT;
									res[n].record_offset = poff_d;
									n = n + 2'd1;
									tpend_d = 1'b0;
									infrag_d = 1'b0;
								end
							end
							default: begin
								if (tpend_d) begin
									res[n].kind = KIND_ABORT;
									n = n + 2'd1;
									tpend_d = 1'b0;
								end
								infrag_d = 1'b0;
							end
						endcase
					end
				end
			end

			if (do_bad) begin
				resync_d = 1'b0;
				if (tpend_d) begin
					res[n].kind = KIND_ABORT;
					n = n + 2'd1;
					tpend_d = 1'b0;
				end
				infrag_d = 1'b0;
				phase_d = bad_skip ? PH_SKIP : PH_HEADER;
			end

			bnext = {1'b0, bpos_q} + (BPW+1)'(1);
			if (bnext >= (BPW+1)'(BLOCK_SIZE)) begin
				bpos_d = '0;
				if (phase_d == PH_SKIP) phase_d = PH_HEADER;
			end else begin
				bpos_d = bnext[BPW-1:0];
			end
			fpos_d = fpos_q + OFFW'(1);

			if (is_last_byte) begin
				if (tpend_d) begin
					res[n].kind = KIND_ABORT;
					n = n + 2'd1;
					tpend_d = 1'b0;
				end
				infrag_d = 1'b0;
				res[n].kind = KIND_END;
				n = n + 2'd1;
				ended_d = 1'b1;
			end
			if (n != 2'd0) begin
				res[n - 2'd1].last = 1'b1;
			end
		end
		res_cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0; start_q <= '0; chk_q <= 1'b1;
			fpos_q <= '0; bpos_q <= '0; phase_q <= PH_HEADER; hshift_q <= '0;
			hcnt_q <= '0; prem_q <= '0; crc_q <= 32'hffffffff; rtype_q <= '0;
			infrag_q <= 1'b0; resync_q <= 1'b0; tpend_q <= 1'b0; emitc_q <= 1'b0;
			poff_q <= '0; choff_q <= '0; ended_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_INITIAL_OFFSET: begin
					init_q <= cfg_wdata;
					start_q <= cfg_start;
					resync_q <= cfg_wdata != '0;
				end
				REG_CHECKSUM_ENABLE: chk_q <= cfg_wdata[0];
				default: ;
			endcase
		end else if (accept) begin
			fpos_q <= fpos_d; bpos_q <= bpos_d; phase_q <= phase_d; hshift_q <= hshift_d;
			hcnt_q <= hcnt_d; prem_q <= prem_d; crc_q <= crc_d; rtype_q <= rtype_d;
			infrag_q <= infrag_d; resync_q <= resync_d; tpend_q <= tpend_d;
			emitc_q <= emitc_d; poff_q <= poff_d; choff_q <= choff_d; ended_q <= ended_d;
		end
	end

endmodule

>>> rtl/lrr_outq.sv
// Result buffer that holds the results of one item and hands them out in order.
module lrr_outq (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic [1:0] load_cnt,
	input  lrr_pkg::result_t load_res [lrr_pkg::MAX_RES],
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output lrr_pkg::result_t out_res
);
	import lrr_pkg::*;

	`include "log_record_reassembler_unit_assert.svh"

	result_t entry_q [MAX_RES];
	logic [1:0] cnt_q, head_q;

	assign out_valid = cnt_q != 2'd0;
	assign out_res = entry_q[head_q];
	// A new item may enter when the buffer is empty or its last result leaves in this cycle.
	assign in_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			head_q <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
			head_q <= '0;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
			head_q <= head_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_res;
		end
	end

	`LRR_ASSERT(a_head_range, (({1'b0, head_q} + {1'b0, cnt_q}) <= 3'd3), "result index overrun")
	`LRR_ASSERT_IMPL(a_load_drained, load, (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready)), "load over pending result")
	`LRR_ASSERT_IMPL(a_final_last, (out_valid && cnt_q == 2'd1), out_res.last, "final result lacks last")

endmodule
